[hdl/dle_pkg.sv]
// Package for the escape/end byte deframer.
// Holds register reset values, register indexes, the configuration struct and sizes.
// No dependencies.
`timescale 1ns / 1ps

package dle_pkg;

	localparam int DEF_MAX_PACKET = 1024;
	localparam int POS_W          = 10;
	localparam int NUM_W          = 16;
	localparam int CFG_ADDR_W     = 3;

	localparam logic [7:0] ESCAPE_RESET = 8'h10;
	localparam logic [7:0] END_RESET    = 8'h03;

	typedef enum logic {
		REG_ESCAPE = 1'b0,
		REG_END    = 1'b1
	} reg_idx_t;

	typedef enum logic {
		KIND_DATA = 1'b0,
		KIND_END  = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0] escape_byte;
		logic [7:0] end_byte;
	} cfg_t;

endpackage

[hdl/dle_if.sv]
// Channel interfaces of the deframer: raw byte input and deframed result output.
// Each carries valid, ready and the payload; depends on nothing.
`timescale 1ns / 1ps

interface dle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface dle_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  data_byte;
	logic [9:0]  position;
	logic        overflow;
	logic [9:0]  packet_size;
	logic [7:0]  packet_id;
	logic [7:0]  packet_subcode;
	logic [15:0] packet_number;

	modport source (output valid, output kind, output data_byte, output position,
		output overflow, output packet_size, output packet_id, output packet_subcode,
		output packet_number, input ready);
	modport sink   (input valid, input kind, input data_byte, input position,
		input overflow, input packet_size, input packet_id, input packet_subcode,
		input packet_number, output ready);
endinterface

[hdl/dle_regs.sv]
// APB register file of the deframer: escape byte and end byte.
// Depends on dle_pkg.
`timescale 1ns / 1ps

module dle_regs
	import dle_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.escape_byte <= ESCAPE_RESET;
			cfg_q.end_byte    <= END_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_ESCAPE: cfg_q.escape_byte <= pwdata[7:0];
				REG_END:    cfg_q.end_byte    <= pwdata[7:0];
				default:    cfg_q             <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ESCAPE: prdata = {24'd0, cfg_q.escape_byte};
			REG_END:    prdata = {24'd0, cfg_q.end_byte};
			default:    prdata = 32'd0;
		endcase
	end

endmodule

[hdl/dle_etx_deframer.sv]
// Top level of the escape/end byte deframer.
// Depends on dle_pkg, dle_if (dle_in_if, dle_out_if) and dle_regs.
`timescale 1ns / 1ps

// One raw byte is taken per cycle unless the output is stalled; each byte is decoded against
// the escape flag and the fill count in a single pass and its result, if any, is registered
// in the output register on acceptance. An escape byte gives no result, a data byte gives a
// data word with its position, and escape followed by the end byte gives an end-of-packet
// word with size, first two bytes and a wrapping packet number. The input is ready whenever
// the output register is empty or being taken, so the block sustains one byte per cycle.
// Positions wrap to zero after MAX_PACKET data bytes; the overflow flag marks the last one.
module dle_etx_deframer
	import dle_pkg::*;
#(
	parameter int MAX_PACKET = DEF_MAX_PACKET
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	dle_in_if.sink                in_ch,
	dle_out_if.source             out_ch
);

	localparam int CW = $clog2(MAX_PACKET);
	localparam int XW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] LAST_POS = CW'(MAX_PACKET - 1);

	cfg_t cfg;

	dle_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic             esc_q;
	logic [CW-1:0]    fill_q;
	logic [7:0]       first_q;
	logic [7:0]       second_q;
	logic [NUM_W-1:0] closed_q;
	logic             out_valid_q;

	logic [7:0]       b;
	logic             in_fire;
	logic             is_end;
	logic             is_esc;
	logic             is_data;
	logic             wrap;
	logic [XW-1:0]    fill_x;
	logic [NUM_W-1:0] closed_inc;

	assign b          = in_ch.in_byte;
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_fire    = in_ch.valid && in_ch.ready;
	assign is_end     = esc_q && (b == cfg.end_byte);
	assign is_esc     = !esc_q && (b == cfg.escape_byte);
	assign is_data    = !is_end && !is_esc;
	assign wrap       = (fill_q == LAST_POS);
	assign fill_x     = XW'(fill_q);
	assign closed_inc = closed_q + NUM_W'(1);

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q    <= 1'b0;
			fill_q   <= '0;
			first_q  <= 8'd0;
			second_q <= 8'd0;
			closed_q <= '0;
		end else if (in_fire) begin
			esc_q <= is_esc;
			if (is_end) begin
				closed_q <= closed_inc;
				fill_q   <= '0;
			end else if (is_data) begin
				if (fill_q == CW'(0)) first_q <= b;
				if (fill_q == CW'(1)) second_q <= b;
				fill_q <= wrap ? '0 : fill_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= !is_esc;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (in_fire && !is_esc) begin
			out_ch.kind           <= is_end ? KIND_END : KIND_DATA;
			out_ch.data_byte      <= is_end ? 8'd0 : b;
			out_ch.position       <= is_end ? '0 : fill_x[POS_W-1:0];
			out_ch.overflow       <= !is_end && wrap;
			out_ch.packet_size    <= is_end ? fill_x[POS_W-1:0] : '0;
			out_ch.packet_id      <= is_end ? first_q : 8'd0;
			out_ch.packet_subcode <= is_end ? second_q : 8'd0;
			out_ch.packet_number  <= is_end ? closed_inc : '0;
		end
	end

	assign out_ch.valid = out_valid_q;

endmodule

[hdl/dle_checker.sv]
// Port-level checker of the deframer and its bind to the top level.
// Depends on dle_pkg and dle_etx_deframer.
`timescale 1ns / 1ps

module dle_checker
	import dle_pkg::*;
#(
	parameter int MAX_PACKET = DEF_MAX_PACKET
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic [7:0]  data_byte,
	input logic [9:0]  position,
	input logic        overflow,
	input logic [9:0]  packet_size,
	input logic [7:0]  packet_number_lo
);

	localparam logic [9:0] LAST_POS = 10'(MAX_PACKET - 1);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output is free");

	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> kind == KIND_DATA && position == LAST_POS)
		else $error("overflow flag off the last buffer position");

	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_END |-> data_byte == 8'd0 && position == 10'd0
			&& !overflow)
		else $error("end word carries data fields");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_DATA |-> packet_size == 10'd0
			&& packet_number_lo == 8'd0)
		else $error("data word carries packet fields");

endmodule

bind dle_etx_deframer dle_checker #(.MAX_PACKET(MAX_PACKET)) u_dle_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_ready         (in_ch.ready),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.kind             (out_ch.kind),
	.data_byte        (out_ch.data_byte),
	.position         (out_ch.position),
	.overflow         (out_ch.overflow),
	.packet_size      (out_ch.packet_size),
	.packet_number_lo (out_ch.packet_number[7:0])
);
